// ----- hdl/lfl_pkg.sv -----
// Shared types, constants and codes for the failed-login lockout table.
package lfl_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Register widths and reset values.
	localparam int LIMIT_W = 8;
	localparam int SECONDS_W = 17;
	localparam int CFG_IDX_W = 2;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd5;
	localparam logic [SECONDS_W-1:0] WINDOW_RESET = 17'd300;
	localparam logic [SECONDS_W-1:0] BLOCK_RESET = 17'd300;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTEMPT_LIMIT = 2'd0,
		CFG_WINDOW_SECONDS = 2'd1,
		CFG_BLOCK_SECONDS = 2'd2
	} cfg_idx_t;

	// Command codes.
	typedef enum logic [1:0] {
		CMD_CHECK = 2'd0,
		CMD_RECORD = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_UPDATE
	} state_t;

	// Input word.
	typedef struct packed {
		logic [1:0] command;
		logic [31:0] source_address;
		logic [31:0] now_seconds;
	} req_t;

	// Result word.
	typedef struct packed {
		logic is_blocked;
		logic entry_found;
		logic [7:0] attempt_count;
		logic dropped;
	} rsp_t;

	// One table entry as held in memory; validity lives in flip-flops.
	typedef struct packed {
		logic [31:0] key;
		logic [7:0] count;
		logic [31:0] last_time;
		logic blocked;
		logic [31:0] unblock_time;
	} entry_t;

	// Controller to update logic: the command and what the scan found.
	typedef struct packed {
		logic [1:0] command;
		logic [31:0] key;
		logic [31:0] now;
		logic hit;
		logic free_found;
		entry_t entry;
	} upd_req_t;

	// Update logic to controller: write-back and result.
	typedef struct packed {
		logic wr_en;
		logic set_valid;
		logic clr_valid;
		entry_t wr_entry;
		rsp_t rsp;
	} upd_res_t;

endpackage

// ----- hdl/lfl_entry_ram.sv -----
// Entry memory: one write port, one read port with registered read data.
module lfl_entry_ram
	import lfl_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem [TABLE_ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/lfl_update.sv -----
// Per-command entry update: computes the write-back entry and the result word.
module lfl_update
	import lfl_pkg::*;
(
	input  logic [LIMIT_W-1:0]   attempt_limit,
	input  logic [SECONDS_W-1:0] window_seconds,
	input  logic [SECONDS_W-1:0] block_seconds,
	input  upd_req_t             req,
	output upd_res_t             res
);

	logic [31:0] left;
	logic        active_old;
	logic [31:0] gap;
	entry_t      ent;
	logic        set_block;

	// Block still running for the stored entry: unblock time lies ahead of now.
	assign left = req.entry.unblock_time - req.now;
	assign active_old = req.entry.blocked && (left != 32'd0) && !left[31];
	assign gap = req.now - req.entry.last_time;

	always_comb begin
		res = '0;
		ent = req.entry;
		set_block = 1'b0;
		case (cmd_t'(req.command))
			CMD_CHECK: begin
				if (req.hit) begin
					res.rsp.entry_found = 1'b1;
					if (active_old) begin
						res.rsp.is_blocked = 1'b1;
					end else if (req.entry.blocked) begin
						// Expired block: drop it along with the count.
						ent.blocked = 1'b0;
						ent.count = 8'd0;
						res.wr_en = 1'b1;
					end
					res.rsp.attempt_count = ent.count;
				end
			end
			CMD_RECORD: begin
				if (req.hit || req.free_found) begin
					if (req.hit) begin
						res.rsp.entry_found = 1'b1;
						if (gap > {15'd0, window_seconds}) begin
							ent.count = 8'd1;
						end else if (ent.count != COUNT_MAX) begin
							ent.count = ent.count + 8'd1;
						end
					end else begin
						// New source in the lowest free entry.
						ent.key = req.key;
						ent.count = 8'd1;
						ent.blocked = 1'b0;
						ent.unblock_time = 32'd0;
						res.set_valid = 1'b1;
					end
					ent.last_time = req.now;
					set_block = (ent.count >= attempt_limit);
					if (set_block) begin
						ent.blocked = 1'b1;
						ent.unblock_time = req.now + {15'd0, block_seconds};
						// A fresh block is running exactly when its length is nonzero.
						res.rsp.is_blocked = (block_seconds != '0);
					end else begin
						res.rsp.is_blocked = active_old && req.hit;
					end
					res.rsp.attempt_count = ent.count;
					res.wr_en = 1'b1;
				end else begin
					res.rsp.dropped = 1'b1;
				end
			end
			CMD_CLEAR: begin
				if (req.hit) begin
					res.rsp.entry_found = 1'b1;
					res.clr_valid = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase
		res.wr_entry = ent;
	end

endmodule

// ----- hdl/lfl_ctrl.sv -----
// Controller: accepts commands, walks the entry memory, writes back and holds the result.
module lfl_ctrl
	import lfl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	output logic             ram_wr_en,
	output logic [IDX_W-1:0] ram_wr_addr,
	output entry_t           ram_wr_data,
	output logic             ram_rd_en,
	output logic [IDX_W-1:0] ram_rd_addr,
	input  entry_t           ram_rd_data,
	output upd_req_t         upd_req,
	input  upd_res_t         upd_res
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	state_t                   state_q, state_d;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         scan_idx_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic                     hit_q;
	logic [IDX_W-1:0]         hit_idx_q;
	entry_t                   hit_entry_q;
	req_t                     cur_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;
	logic                     accept;
	logic                     out_free;
	logic                     finish;
	logic                     free_found;
	logic [IDX_W-1:0]         free_idx;
	logic [IDX_W-1:0]         wr_idx;

	assign accept = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_idx_q == LAST_IDX) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		req_stall = 1'b1;
		ram_rd_en = 1'b0;
		finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_SCAN: begin
				ram_rd_en = 1'b1;
			end
			ST_WAIT: begin
				ram_rd_en = 1'b0;
			end
			ST_UPDATE: begin
				finish = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lowest free entry, taken straight from the valid bits.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// Memory walk: one read address per cycle, data compared from the registered read data.
	assign ram_rd_addr = scan_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			hit_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_rd_en;
			rd_idx_s1 <= scan_idx_q;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (ram_rd_en && scan_idx_q != LAST_IDX) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (accept) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && !hit_q && valid_q[rd_idx_s1]
					&& ram_rd_data.key == cur_q.source_address) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Captured command and matching entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= req;
		end
		if (rd_vld_s1 && !hit_q && valid_q[rd_idx_s1]
				&& ram_rd_data.key == cur_q.source_address) begin
			hit_idx_q <= rd_idx_s1;
			hit_entry_q <= ram_rd_data;
		end
	end

	// Request to the update logic.
	always_comb begin
		upd_req.command = cur_q.command;
		upd_req.key = cur_q.source_address;
		upd_req.now = cur_q.now_seconds;
		upd_req.hit = hit_q;
		upd_req.free_found = free_found;
		upd_req.entry = hit_entry_q;
	end

	// Write-back in the update cycle.
	assign wr_idx = hit_q ? hit_idx_q : free_idx;
	assign ram_wr_en = finish && upd_res.wr_en;
	assign ram_wr_addr = wr_idx;
	assign ram_wr_data = upd_res.wr_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (finish) begin
			if (upd_res.set_valid) begin
				valid_q[wr_idx] <= 1'b1;
			end else if (upd_res.clr_valid) begin
				valid_q[wr_idx] <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= upd_res.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ----- hdl/failed_login_lockout_table.sv -----
// Words are handled one at a time: the walk over the entry memory through its single read
// port (one entry per cycle), the wait for the registered read data, the write-back state and
// the idle state that takes the next word; a stalled result holds the write-back state.
// A new word is taken while the previous result still waits in the output register.
// Reset clears all valid bits at once and loads the register defaults (limit 5, window
// 300 s, block 300 s); the memory contents need no clearing.
module failed_login_lockout_table
	import lfl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SECONDS_W-1:0] cfg_data
);

	logic [LIMIT_W-1:0]   attempt_limit_q;
	logic [SECONDS_W-1:0] window_seconds_q;
	logic [SECONDS_W-1:0] block_seconds_q;
	logic                 ram_wr_en;
	logic [IDX_W-1:0]     ram_wr_addr;
	entry_t               ram_wr_data;
	logic                 ram_rd_en;
	logic [IDX_W-1:0]     ram_rd_addr;
	entry_t               ram_rd_data;
	upd_req_t             upd_req;
	upd_res_t             upd_res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attempt_limit_q <= LIMIT_RESET;
			window_seconds_q <= WINDOW_RESET;
			block_seconds_q <= BLOCK_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ATTEMPT_LIMIT: begin
					attempt_limit_q <= cfg_data[LIMIT_W-1:0];
				end
				CFG_WINDOW_SECONDS: begin
					window_seconds_q <= cfg_data;
				end
				CFG_BLOCK_SECONDS: begin
					block_seconds_q <= cfg_data;
				end
				default: begin
					attempt_limit_q <= attempt_limit_q;
				end
			endcase
		end
	end

	lfl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.upd_req     (upd_req),
		.upd_res     (upd_res)
	);

	lfl_entry_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	lfl_update u_update (
		.attempt_limit  (attempt_limit_q),
		.window_seconds (window_seconds_q),
		.block_seconds  (block_seconds_q),
		.req            (upd_req),
		.res            (upd_res)
	);

endmodule

// ----- hdl/lfl_checker.sv -----
// Port-level assertions for the lockout table, bound to the top level.
module lfl_checker
	import lfl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A taken word keeps the input side stalled while the table is walked.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("input taken again right after an accept");

	// A dropped record reports nothing else.
	a_dropped_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.dropped) |-> (!rsp.is_blocked && !rsp.entry_found
			&& rsp.attempt_count == 8'd0))
		else $error("dropped result carries entry data");

	// A blocked source always has failures on record.
	a_blocked_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_blocked) |-> (rsp.attempt_count != 8'd0))
		else $error("blocked source with zero count");

	// A stalled result stays in place.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

endmodule

bind failed_login_lockout_table lfl_checker u_lfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
